[hw/rtl/ttu_pkg.sv]
`default_nettype none

package ttu_pkg;

  // Field and register widths fixed by the interface.
  localparam int CHAR_W    = 8;
  localparam int RADIX_W   = 6;
  localparam int REG_W     = 32;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [RADIX_W-1:0] RADIX_MODE_RST = 6'd0;
  localparam logic [REG_W-1:0]   MIN_VALUE_RST  = 32'h0000_0000;
  localparam logic [REG_W-1:0]   MAX_VALUE_RST  = 32'hFFFF_FFFF;

  // Radix constants.
  localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_W-1:0] RADIX_ONE  = 6'd1;
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_SMALL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_RADIX = 3'd4;

  // Where the datapath takes the radix for the current character from.
  typedef enum logic [2:0] {
    RSEL_KEEP,     // radix already fixed
    RSEL_MODE,     // radix mode as written, auto stays zero
    RSEL_DEC,      // radix mode, auto becomes decimal
    RSEL_HEX,      // hex after a 0x prefix
    RSEL_OCT       // octal if still undecided after a leading zero
  } radix_sel_t;

  // How the string ended.
  typedef enum logic [1:0] {
    FIN_NO_NUMBER,
    FIN_NUMBER,
    FIN_BAD_RADIX
  } fin_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    radix_sel_t radix_sel;
    logic       load_radix;
    logic       set_sign;
    logic       acc_load;
    logic       finish;
    fin_kind_t  fin_kind;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_bad;
    logic mode_zero_or_hex;
    logic is_space;
    logic is_sign;
    logic is_zero_char;
    logic is_x;
    logic digit_ok;
    logic res_valid;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/ttu_in_if.sv]
`default_nettype none

interface ttu_in_if
  import ttu_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/ttu_out_if.sv]
`default_nettype none

interface ttu_out_if
  import ttu_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/ttu_cfg_if.sv]
`default_nettype none

interface ttu_cfg_if
  import ttu_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/ttu_ctrl.sv]
`default_nettype none

module ttu_ctrl
  import ttu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_last,
  output logic     in_ready,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_HEXPFX,
    PH_DIGITS,
    PH_STOPPED,
    PH_BAD
  } phase_t;

  phase_t phase;
  phase_t phase_next;
  logic   finish;
  logic   finish_next;
  logic   step;
  logic   close_ok;

  // A new character is taken unless a string is waiting to close.
  assign in_ready = !finish;
  assign step     = in_valid && in_ready;

  // A string closes once the result register is free or being emptied.
  assign close_ok = finish && (!stat.res_valid || out_ready);

  // Scan decisions for the current character, and closing of a string.
  always_comb begin
    logic first_sig;
    logic take;
    first_sig     = 1'b0;
    take          = 1'b0;
    phase_next    = phase;
    finish_next   = (finish && !close_ok) || (step && in_last);
    cmd           = '0;
    cmd.radix_sel = RSEL_KEEP;
    cmd.fin_kind  = FIN_NO_NUMBER;

    if (finish) begin
      if (close_ok) begin
        cmd.finish = 1'b1;
        case (phase)
          PH_BAD:             cmd.fin_kind = FIN_BAD_RADIX;
          PH_DIGITS, PH_ZERO: cmd.fin_kind = FIN_NUMBER;
          default:            cmd.fin_kind = FIN_NO_NUMBER;
        endcase
        phase_next = PH_SPACE;
      end
    end else if (step) begin
      if (stat.mode_bad) begin
        phase_next = PH_BAD;
      end else begin
        case (phase)
          PH_SPACE: begin
            if (stat.is_space) begin
              phase_next = PH_SPACE;
            end else if (stat.is_sign) begin
              cmd.set_sign = 1'b1;
              phase_next   = PH_SIGNED;
            end else begin
              first_sig = 1'b1;
            end
          end
          PH_SIGNED: begin
            first_sig = 1'b1;
          end
          PH_ZERO: begin
            cmd.load_radix = 1'b1;
            if (stat.is_x) begin
              cmd.radix_sel = RSEL_HEX;
              phase_next    = PH_HEXPFX;
            end else begin
              cmd.radix_sel = RSEL_OCT;
              take          = 1'b1;
            end
          end
          PH_HEXPFX, PH_DIGITS: begin
            take = 1'b1;
          end
          default: begin
            phase_next = phase;
          end
        endcase

        // First significant character: a leading zero may open a prefix.
        if (first_sig) begin
          cmd.load_radix = 1'b1;
          if (stat.is_zero_char && stat.mode_zero_or_hex) begin
            cmd.radix_sel = RSEL_MODE;
            phase_next    = PH_ZERO;
          end else begin
            cmd.radix_sel = RSEL_DEC;
            take          = 1'b1;
          end
        end

        // A digit that does not fit the radix or the word stops the scan.
        if (take) begin
          cmd.acc_load = stat.digit_ok;
          phase_next   = stat.digit_ok ? PH_DIGITS : PH_STOPPED;
        end
      end
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SPACE;
      finish <= 1'b0;
    end else begin
      phase  <= phase_next;
      finish <= finish_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ttu_dp.sv]
`default_nettype none

module ttu_dp
  import ttu_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [CHAR_W-1:0]    char_code,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [VALUE_W-1:0]   value,
  output logic [STATUS_W-1:0]  status
);

  localparam int PROD_W = WORD_BITS + RADIX_W;
  localparam int CMP_W  = (WORD_BITS > REG_W) ? WORD_BITS : REG_W;

  logic [RADIX_W-1:0]   radix_mode;
  logic [REG_W-1:0]     min_value;
  logic [REG_W-1:0]     max_value;
  logic                 minus_seen;
  logic [RADIX_W-1:0]   radix_now;
  logic [WORD_BITS-1:0] accumulator;

  logic [RADIX_W-1:0]   eff_radix;
  logic [RADIX_W-1:0]   digit;
  logic [PROD_W-1:0]    prod;
  logic [WORD_BITS-1:0] final_word;
  logic [CMP_W-1:0]     final_cmp;
  logic [STATUS_W-1:0]  final_status;

  // Digit value of a character, RADIX_MAX when it is no digit at all.
  function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [RADIX_W-1:0] d;
    d = RADIX_MAX;
    if (c >= "0" && c <= "9") begin
      d = RADIX_W'(c - "0");
    end else if (c >= "a" && c <= "z") begin
      d = RADIX_W'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "Z") begin
      d = RADIX_W'(c - "A" + 8'd10);
    end
    return d;
  endfunction

  // Character classes seen by the controller.
  always_comb begin
    stat                  = '0;
    stat.mode_bad         = (radix_mode == RADIX_ONE) || (radix_mode > RADIX_MAX);
    stat.mode_zero_or_hex = (radix_mode == RADIX_AUTO) || (radix_mode == RADIX_HEX);
    stat.is_space         = char_code inside {8'd32, [8'd9:8'd13]};
    stat.is_sign          = (char_code == "+") || (char_code == "-");
    stat.is_zero_char     = (char_code == "0");
    stat.is_x             = (char_code == "x") || (char_code == "X");
    stat.digit_ok         = (eff_radix >= RADIX_MIN) && (digit < eff_radix) &&
                            (prod[PROD_W-1:WORD_BITS] == '0);
    stat.res_valid        = out_valid;
  end

  // Radix that applies to the current character.
  always_comb begin
    case (cmd.radix_sel)
      RSEL_KEEP: eff_radix = radix_now;
      RSEL_MODE: eff_radix = radix_mode;
      RSEL_DEC:  eff_radix = (radix_mode == RADIX_AUTO) ? RADIX_DEC : radix_mode;
      RSEL_HEX:  eff_radix = RADIX_HEX;
      RSEL_OCT:  eff_radix = (radix_now == RADIX_AUTO) ? RADIX_OCT : radix_now;
      default:   eff_radix = radix_now;
    endcase
  end

  // Multiply-accumulate; any bit above the word means overflow.
  assign digit = digit_of(char_code);
  assign prod  = PROD_W'(accumulator) * PROD_W'(eff_radix) + PROD_W'(digit);

  // Sign, range check and status once the string has ended.
  assign final_word = minus_seen ? (~accumulator + 1'b1) : accumulator;
  assign final_cmp  = CMP_W'(final_word);

  always_comb begin
    case (cmd.fin_kind)
      FIN_BAD_RADIX: final_status = ST_BAD_RADIX;
      FIN_NUMBER: begin
        if (final_cmp > CMP_W'(max_value)) begin
          final_status = ST_TOO_BIG;
        end else if (final_cmp < CMP_W'(min_value)) begin
          final_status = ST_TOO_SMALL;
        end else begin
          final_status = ST_OK;
        end
      end
      default: final_status = ST_INVALID;
    endcase
  end

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix_mode <= RADIX_MODE_RST;
      min_value  <= MIN_VALUE_RST;
      max_value  <= MAX_VALUE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIX_MODE: radix_mode <= cfg_data[RADIX_W-1:0];
        REG_MIN_VALUE:  min_value  <= cfg_data;
        REG_MAX_VALUE:  max_value  <= cfg_data;
        default:        radix_mode <= radix_mode;
      endcase
    end
  end

  // Per-string scan state, cleared when a string closes.
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      minus_seen  <= 1'b0;
      radix_now   <= RADIX_AUTO;
      accumulator <= '0;
    end else begin
      if (cmd.set_sign) begin
        minus_seen <= (char_code == "-");
      end
      if (cmd.load_radix) begin
        radix_now <= eff_radix;
      end
      if (cmd.acc_load) begin
        accumulator <= prod[WORD_BITS-1:0];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= final_status;
      value  <= (final_status == ST_OK) ? final_cmp[VALUE_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/text_to_unsigned_with_range_check.sv]
`default_nettype none

// Channel  Role  Carries                         Request taken when
// chars    sink  char_code[7:0], is_last         valid && ready
// result   src   value[31:0], status[2:0]        valid && ready
// cfg      sink  index[1:0], data[31:0]          valid && ready (ready always high)
//
// Characters are taken while no string waits to close; the radix
// multiply-accumulate and its overflow check are combinational, so each
// character is folded in as it is taken. After the last character, a separate
// closing step moves the sign, range check and status into the result register.
// Reset is synchronous; it restores the configuration defaults and the scan.
// A result waiting in the output register does not stall the next string;
// only closing a further string waits for that result to be taken.

module text_to_unsigned_with_range_check
  import ttu_pkg::*;
#(
  parameter int WORD_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  ttu_in_if.sink           chars,
  ttu_out_if.source        result,
  ttu_cfg_if.sink          cfg
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  // Scan controller.
  ttu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chars.valid),
    .in_last   (chars.is_last),
    .in_ready  (chars.ready),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Accumulator, configuration and result datapath.
  ttu_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_code (chars.char_code),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .value     (result.value),
    .status    (result.status)
  );

endmodule

`default_nettype wire

[sim/ttu_parse_monitor.sv]
module ttu_parse_monitor
  import ttu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ttu_in_if    chars,
  ttu_out_if   result,
  ttu_cfg_if   cfg,
  output int   errors,
  output int   pending
);

  typedef enum logic [2:0] {
    SCAN_SPACE,
    SCAN_SIGNED,
    SCAN_ZERO,
    SCAN_HEXPFX,
    SCAN_DIGITS,
    SCAN_STOPPED,
    SCAN_BAD
  } scan_phase_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
  } parse_result_t;

  // Shadow copy of the configuration registers.
  logic [RADIX_W-1:0] radix_mode;
  logic [REG_W-1:0]   min_value;
  logic [REG_W-1:0]   max_value;

  // Scan state of the string being parsed.
  scan_phase_t        phase;
  logic               minus;
  logic [RADIX_W-1:0] radix_now;
  logic [VALUE_W-1:0] acc;

  parse_result_t expected_q[$];
  int            tally;

  function automatic int digit_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "z") return c - "a" + 10;
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    return 36;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void clear_scan();
    phase     = SCAN_SPACE;
    minus     = 1'b0;
    radix_now = RADIX_AUTO;
    acc       = '0;
  endfunction

  // A digit outside the radix, or one that would carry the value past the
  // word, ends the scan for good.
  function automatic void take_digit(logic [7:0] c);
    int          d;
    logic [63:0] grown;
    d = digit_val(c);
    if (d >= radix_now) begin
      phase = SCAN_STOPPED;
      return;
    end
    grown = {32'd0, acc} * 64'(radix_now) + 64'(d);
    if (grown > 64'hFFFF_FFFF) begin
      phase = SCAN_STOPPED;
    end else begin
      acc   = grown[VALUE_W-1:0];
      phase = SCAN_DIGITS;
    end
  endfunction

  // Advance the scan by one character; the radix mode is read each time.
  function automatic void scan_char(logic [7:0] c);
    logic [RADIX_W-1:0] mode;
    mode = radix_mode;
    if (mode == RADIX_ONE || mode > RADIX_MAX) begin
      phase = SCAN_BAD;
      return;
    end
    case (phase)
      SCAN_SPACE, SCAN_SIGNED: begin
        if (phase == SCAN_SPACE && is_blank(c)) return;
        if (phase == SCAN_SPACE && (c == "+" || c == "-")) begin
          minus = (c == "-");
          phase = SCAN_SIGNED;
          return;
        end
        if (c == "0" && (mode == RADIX_AUTO || mode == RADIX_HEX)) begin
          radix_now = mode;
          acc       = '0;
          phase     = SCAN_ZERO;
          return;
        end
        radix_now = (mode == RADIX_AUTO) ? RADIX_DEC : mode;
        take_digit(c);
      end
      SCAN_ZERO: begin
        if (c == "x" || c == "X") begin
          radix_now = RADIX_HEX;
          phase     = SCAN_HEXPFX;
          return;
        end
        if (radix_now == RADIX_AUTO) radix_now = RADIX_OCT;
        take_digit(c);
      end
      SCAN_HEXPFX, SCAN_DIGITS: begin
        take_digit(c);
      end
      default: begin
      end
    endcase
  endfunction

  // Sign, range check and status at the end of a string.
  function automatic parse_result_t close_string();
    parse_result_t      r;
    logic [VALUE_W-1:0] v;
    r.value = '0;
    if (phase == SCAN_BAD) begin
      r.status = ST_BAD_RADIX;
    end else if (phase == SCAN_DIGITS || phase == SCAN_ZERO) begin
      v = minus ? -acc : acc;
      if (v > max_value) begin
        r.status = ST_TOO_BIG;
      end else if (v < min_value) begin
        r.status = ST_TOO_SMALL;
      end else begin
        r.status = ST_OK;
        r.value  = v;
      end
    end else begin
      r.status = ST_INVALID;
    end
    clear_scan();
    return r;
  endfunction

  // Track register writes and characters, then compare each result.
  always @(posedge clk) begin
    parse_result_t want;
    if (rst) begin
      radix_mode = RADIX_MODE_RST;
      min_value  = MIN_VALUE_RST;
      max_value  = MAX_VALUE_RST;
      clear_scan();
      expected_q.delete();
      tally = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_RADIX_MODE: radix_mode = cfg.data[RADIX_W-1:0];
          REG_MIN_VALUE:  min_value  = cfg.data;
          REG_MAX_VALUE:  max_value  = cfg.data;
          default: begin
          end
        endcase
      end
      if (chars.valid && chars.ready) begin
        scan_char(chars.char_code);
        if (chars.is_last) expected_q.push_back(close_string());
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no string waiting: value %0h status %0d",
                 result.value, result.status);
          tally++;
        end else begin
          want = expected_q.pop_front();
          if (result.value !== want.value) begin
            $error("value: expected %0h, got %0h", want.value, result.value);
            tally++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            tally++;
          end
        end
      end
    end
    pending <= expected_q.size();
    errors  <= tally;
  end

endmodule

[sim/text_to_unsigned_with_range_check_tb.sv]
module text_to_unsigned_with_range_check_tb;
  import ttu_pkg::*;

  localparam int                 LIMIT          = 200000;
  localparam int                 PHASES         = 10;
  localparam int                 HOLD_CYCLES    = 400;
  localparam logic [RADIX_W-1:0] RADIX_ALL_ONES = 6'h3F;
  localparam logic [RADIX_W-1:0] PHASE_MODE [PHASES] = '{
    RADIX_AUTO, RADIX_DEC, RADIX_HEX, RADIX_MIN, RADIX_MAX,
    RADIX_OCT, RADIX_AUTO, RADIX_ONE, RADIX_ALL_ONES, RADIX_AUTO
  };

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   cycles;
  logic steady;
  logic hold_go;
  logic held_done;
  logic [7:0] text_buf[$];

  ttu_in_if  chars_if ();
  ttu_out_if result_if ();
  ttu_cfg_if cfg_if ();

  text_to_unsigned_with_range_check #(.WORD_BITS(32)) dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .result (result_if),
    .cfg    (cfg_if)
  );

  ttu_parse_monitor mon (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .result  (result_if),
    .cfg     (cfg_if),
    .errors  (fail_count),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up on a hung run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off while requests keep coming.
  initial begin
    held_done = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held_done) begin
        held_done = 1'b1;
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_if.ready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  // Offer one character and wait until it is taken.
  task automatic send_char(input logic [7:0] c, input logic last);
    if (!steady && $urandom_range(99) < 10) begin
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    chars_if.valid     <= 1'b1;
    chars_if.char_code <= c;
    chars_if.is_last   <= last;
    do @(posedge clk); while (!chars_if.ready);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  // Wait for all outstanding results, then let the pipeline drain.
  task automatic settle();
    chars_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [RADIX_W-1:0] mode,
                            input logic [REG_W-1:0] lo, input logic [REG_W-1:0] hi);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_RADIX_MODE;
    cfg_if.data  <= {{(REG_W-RADIX_W){1'b0}}, mode};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= REG_MIN_VALUE;
    cfg_if.data  <= lo;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= REG_MAX_VALUE;
    cfg_if.data  <= hi;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // Build one string: mostly a well-formed number with random blanks, sign,
  // prefix, case and size, sometimes followed by junk; the rest is noise.
  task automatic make_string(input logic [RADIX_W-1:0] mode);
    string       alphabet;
    logic [63:0] num;
    logic [7:0]  dch;
    logic [7:0]  digs[$];
    int          radix;
    int          d;
    int          sel;
    alphabet = " +-0xX7fZ";
    text_buf.delete();
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(1))
          text_buf.push_back(8'($urandom_range(0, 255)));
        else
          text_buf.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
      end
    end else begin
      // Leading blanks: space or one of tab through carriage return.
      repeat ($urandom_range(0, 2)) begin
        dch = 8'($urandom_range(8, 13));
        text_buf.push_back(dch == 8'd8 ? 8'd32 : dch);
      end
      sel = $urandom_range(0, 3);
      if (sel == 0) text_buf.push_back("+");
      if (sel == 1) text_buf.push_back("-");
      // Prefix and the radix the digits are written in.
      if (mode == RADIX_AUTO) begin
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
          radix = 16;
          text_buf.push_back("0");
          text_buf.push_back($urandom_range(1) ? "x" : "X");
        end else if (sel == 1) begin
          radix = 8;
          text_buf.push_back("0");
        end else begin
          radix = 10;
        end
      end else if (mode == RADIX_ONE || mode > RADIX_MAX) begin
        radix = 10;
      end else begin
        radix = mode;
        if (mode == RADIX_HEX && $urandom_range(1)) begin
          text_buf.push_back("0");
          text_buf.push_back("x");
        end
      end
      if ($urandom_range(7) == 0) text_buf.push_back("0");
      // Magnitude: zero, near the top of the word, just past it, or random.
      sel = $urandom_range(0, 9);
      if (sel == 0)      num = 64'd0;
      else if (sel == 1) num = 64'hFFFF_FFFF - 64'($urandom_range(0, 3));
      else if (sel == 2) num = 64'h1_0000_0000 + 64'($urandom_range(0, 3));
      else if (sel == 3) num = {32'($urandom), 32'($urandom)};
      else               num = 64'($urandom >> $urandom_range(0, 31));
      do begin
        d = int'(num % 64'(radix));
        if (d < 10) dch = 8'("0" + d);
        else        dch = 8'(($urandom_range(1) ? "a" : "A") + d - 10);
        digs.push_front(dch);
        num = num / 64'(radix);
      end while (num != 0);
      foreach (digs[i]) text_buf.push_back(digs[i]);
      if ($urandom_range(9) == 0) text_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Stimulus: directed strings, then random phases under several settings.
  initial begin
    logic [RADIX_W-1:0] mode;
    logic [REG_W-1:0]   lo;
    logic [REG_W-1:0]   hi;
    logic [REG_W-1:0]   tmp;
    int                 budget;
    int                 sent;
    rst                <= 1'b1;
    chars_if.valid     <= 1'b0;
    chars_if.char_code <= '0;
    chars_if.is_last   <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_RADIX_MODE;
    cfg_if.data        <= '0;
    steady  = 1'b0;
    hold_go = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: lone and negative zero, empty prefix, no digits, octal,
    // trailing text, zero byte, top byte, hex prefix, blanks with a sign.
    send_str("0");
    send_str("-0");
    send_str("0x");
    send_str("\t-");
    send_str("07");
    send_str("12z");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    send_str("0X1f");
    send_str(" +9");

    // Bad radix modes, then the radix and range extremes.
    settle();
    write_regs(RADIX_ONE, MIN_VALUE_RST, MAX_VALUE_RST);
    send_str("5");
    settle();
    write_regs(RADIX_ALL_ONES, MIN_VALUE_RST, MAX_VALUE_RST);
    send_str("7");
    settle();
    write_regs(RADIX_MAX, '0, '0);
    send_str("zZ");
    send_str("0");
    settle();
    write_regs(RADIX_MIN, '1, '1);
    send_str("-1");
    send_str("1");
    settle();
    write_regs(RADIX_HEX, 32'h10, 32'h20);
    send_str("0x1f");
    send_str("F");

    for (int p = 0; p < PHASES; p++) begin
      settle();
      mode = (p == PHASES - 1) ? RADIX_MAX - 6'($urandom_range(1, 33)) : PHASE_MODE[p];
      // Full range, an ordered window, or arbitrary bounds.
      if (p % 3 == 0) begin
        lo = MIN_VALUE_RST;
        hi = MAX_VALUE_RST;
      end else begin
        lo = $urandom >> $urandom_range(8, 31);
        hi = $urandom >> $urandom_range(0, 16);
        if (p % 3 == 1 && lo > hi) begin
          tmp = lo;
          lo  = hi;
          hi  = tmp;
        end
      end
      write_regs(mode, lo, hi);
      steady = (p == 2);
      if (p == 1) hold_go <= 1'b1;
      budget = (mode == RADIX_ONE || mode > RADIX_MAX) ? 30 : 88;
      sent = 0;
      while (sent < budget) begin
        make_string(mode);
        send_text();
        sent += text_buf.size();
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
